// ----- src/mer_pkg.sv -----
// Shared types and constants of the midpoint ellipse rasterizer.
package mer_pkg;

	localparam int COORD_W = 13;
	localparam int DEC_W = 48;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_MUL4,
		ST_EVAL,
		ST_SW1,
		ST_SW2,
		ST_SW3,
		ST_SW4,
		ST_UPD1,
		ST_UPD2,
		ST_UPD3,
		ST_EMIT,
		ST_EMIT_NOP
	} state_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_LOAD,
		DP_RX2,
		DP_RY2,
		DP_B0,
		DP_INIT,
		DP_EVAL,
		DP_SW1,
		DP_SW2,
		DP_SW3,
		DP_SW4,
		DP_UPD1,
		DP_UPD2,
		DP_UPD3,
		DP_EMIT,
		DP_EMIT_NOP
	} dp_op_t;

	typedef struct packed {
		logic active;
		logic need_switch;
	} status_t;

endpackage

// ----- src/mer_dp.sv -----
// Datapath of the midpoint ellipse rasterizer: point, decision value and shared multiplier.
module mer_dp import mer_pkg::*; #(
	parameter int RADIUS_BITS = 10,
	parameter int CENTER_BITS = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dp_op_t                        cmd,
	output status_t                       status,
	input  logic [RADIUS_BITS-1:0]        radius_x,
	input  logic [RADIUS_BITS-1:0]        radius_y,
	input  logic [CENTER_BITS-1:0]        center_x,
	input  logic [CENTER_BITS-1:0]        center_y,
	output logic signed [COORD_W-1:0]     px_pp,
	output logic signed [COORD_W-1:0]     py_pp,
	output logic signed [COORD_W-1:0]     px_pm,
	output logic signed [COORD_W-1:0]     py_pm,
	output logic signed [COORD_W-1:0]     px_mp,
	output logic signed [COORD_W-1:0]     py_mp,
	output logic signed [COORD_W-1:0]     px_mm,
	output logic signed [COORD_W-1:0]     py_mm,
	output logic                          last_point,
	output logic                          no_point
);

	localparam int RB = RADIUS_BITS;
	localparam int CB = CENTER_BITS;
	localparam int PW = 3 * RB;
	localparam int SW = ((CB > RB) ? CB : RB) + 1;
	localparam int EW = (SW > COORD_W) ? SW : COORD_W;

	logic [RB-1:0]     rx_q, ry_q, x_q, y_q, y_next;
	logic [CB-1:0]     cx_q, cy_q;
	logic [2*RB-1:0]   rx2_q, ry2_q;
	logic [PW-1:0]     a_q, b_q;
	logic [DEC_W-1:0]  rxry_q, dec_q, tmp_q, term_q;
	logic              r2_q, active_q, dx_q, dy_q, kr2_q;
	logic [DEC_W-1:0]  mul_a, mul_p, init_dec, kterm;
	logic [RB:0]       mul_b;
	logic [DEC_W+RB:0] mul_full;
	logic              dec_neg, dec_pos;
	logic [EW-1:0]     xp, xm, yp, ym;

	assign dec_neg = dec_q[DEC_W-1];
	assign dec_pos = !dec_neg && (dec_q != '0);
	assign status.active = active_q;
	assign status.need_switch = !r2_q && !(a_q < b_q);
	assign y_next = dy_q ? (y_q - 1'b1) : y_q;

	assign init_dec = (DEC_W'(ry2_q) << 2) - (DEC_W'(b_q) << 2) + DEC_W'(rx2_q);
	assign kterm = kr2_q ? (DEC_W'(rx2_q) << 2) : (DEC_W'(ry2_q) << 2);

	assign xp = EW'(cx_q) + EW'(x_q);
	assign xm = EW'(cx_q) - EW'(x_q);
	assign yp = EW'(cy_q) + EW'(y_q);
	assign ym = EW'(cy_q) - EW'(y_q);

	always_comb begin
		unique case (cmd)
			DP_RX2: begin
				mul_a = DEC_W'(rx_q);
				mul_b = (RB+1)'(rx_q);
			end
			DP_RY2: begin
				mul_a = DEC_W'(ry_q);
				mul_b = (RB+1)'(ry_q);
			end
			DP_B0: begin
				mul_a = DEC_W'(rx2_q);
				mul_b = (RB+1)'(ry_q);
			end
			DP_INIT: begin
				mul_a = DEC_W'(b_q);
				mul_b = (RB+1)'(ry_q);
			end
			DP_SW2: begin
				mul_a = tmp_q;
				mul_b = {x_q, 1'b1};
			end
			DP_SW3: begin
				mul_a = tmp_q;
				mul_b = (RB+1)'(y_q - 1'b1);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_full = mul_a * mul_b;
	assign mul_p = mul_full[DEC_W-1:0];

	always_ff @(posedge clk) begin
		unique case (cmd)
			DP_LOAD: begin
				rx_q <= radius_x;
				ry_q <= radius_y;
				cx_q <= center_x;
				cy_q <= center_y;
				x_q <= '0;
				y_q <= radius_y;
				a_q <= '0;
			end
			DP_RX2: rx2_q <= mul_p[2*RB-1:0];
			DP_RY2: ry2_q <= mul_p[2*RB-1:0];
			DP_B0: b_q <= mul_p[PW-1:0];
			DP_INIT: begin
				rxry_q <= mul_p;
				dec_q <= init_dec;
			end
			DP_EVAL: begin
				if (r2_q) begin
					dx_q <= !dec_pos;
					dy_q <= 1'b1;
				end else begin
					dx_q <= 1'b1;
					dy_q <= !dec_neg;
				end
				kr2_q <= r2_q;
			end
			DP_SW1: tmp_q <= (DEC_W'(a_q) << 1) + DEC_W'(ry2_q);
			DP_SW2: begin
				dec_q <= mul_p;
				tmp_q <= DEC_W'(b_q - PW'(rx2_q));
			end
			DP_SW3: tmp_q <= mul_p;
			DP_SW4: dec_q <= dec_q + (tmp_q << 2) - (rxry_q << 2);
			DP_UPD1: begin
				if (dx_q) begin
					x_q <= x_q + 1'b1;
					a_q <= a_q + PW'(ry2_q);
				end
				if (dy_q) begin
					y_q <= y_next;
					b_q <= b_q - PW'(rx2_q);
				end
			end
			DP_UPD2: term_q <= (dx_q ? (DEC_W'(a_q) << 3) : '0)
				- (dy_q ? (DEC_W'(b_q) << 3) : '0);
			DP_UPD3: dec_q <= dec_q + term_q + kterm;
			DP_EMIT: begin
				px_pp <= xp[COORD_W-1:0];
				py_pp <= yp[COORD_W-1:0];
				px_pm <= xp[COORD_W-1:0];
				py_pm <= ym[COORD_W-1:0];
				px_mp <= xm[COORD_W-1:0];
				py_mp <= yp[COORD_W-1:0];
				px_mm <= xm[COORD_W-1:0];
				py_mm <= ym[COORD_W-1:0];
				last_point <= (y_q == '0);
				no_point <= 1'b0;
			end
			DP_EMIT_NOP: begin
				px_pp <= '0;
				py_pp <= '0;
				px_pm <= '0;
				py_pm <= '0;
				px_mp <= '0;
				py_mp <= '0;
				px_mm <= '0;
				py_mm <= '0;
				last_point <= 1'b0;
				no_point <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r2_q <= 1'b0;
			active_q <= 1'b0;
		end else begin
			unique case (cmd)
				DP_LOAD: begin
					r2_q <= 1'b0;
					active_q <= (radius_y != '0);
				end
				DP_SW4: r2_q <= 1'b1;
				DP_UPD1: active_q <= (y_next != '0);
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- src/mer_ctrl.sv -----
// Controller state machine of the midpoint ellipse rasterizer.
module mer_ctrl import mer_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_op,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	output dp_op_t  cmd,
	input  status_t status
);

	state_t state_q, state_d;
	logic   out_valid_q, out_free, emit;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign emit = (cmd == DP_EMIT) || (cmd == DP_EMIT_NOP);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					priority if (in_op == OP_START) begin
						state_d = ST_MUL1;
					end else if (status.active) begin
						state_d = ST_EVAL;
					end else begin
						state_d = ST_EMIT_NOP;
					end
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_MUL3;
			ST_MUL3: state_d = ST_MUL4;
			ST_MUL4: state_d = ST_EMIT;
			ST_EVAL: state_d = status.need_switch ? ST_SW1 : ST_UPD1;
			ST_SW1: state_d = ST_SW2;
			ST_SW2: state_d = ST_SW3;
			ST_SW3: state_d = ST_SW4;
			ST_SW4: state_d = ST_EVAL;
			ST_UPD1: state_d = ST_UPD2;
			ST_UPD2: state_d = ST_UPD3;
			ST_UPD3: state_d = ST_EMIT;
			ST_EMIT, ST_EMIT_NOP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE: cmd = (in_valid && (in_op == OP_START)) ? DP_LOAD : DP_NONE;
			ST_MUL1: cmd = DP_RX2;
			ST_MUL2: cmd = DP_RY2;
			ST_MUL3: cmd = DP_B0;
			ST_MUL4: cmd = DP_INIT;
			ST_EVAL: cmd = DP_EVAL;
			ST_SW1: cmd = DP_SW1;
			ST_SW2: cmd = DP_SW2;
			ST_SW3: cmd = DP_SW3;
			ST_SW4: cmd = DP_SW4;
			ST_UPD1: cmd = DP_UPD1;
			ST_UPD2: cmd = DP_UPD2;
			ST_UPD3: cmd = DP_UPD3;
			ST_EMIT: cmd = out_free ? DP_EMIT : DP_NONE;
			ST_EMIT_NOP: cmd = out_free ? DP_EMIT_NOP : DP_NONE;
			default: cmd = DP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/midpoint_ellipse_rasterizer.sv -----
// Top level of the midpoint ellipse rasterizer.
// A start word runs four multiplier passes; a step word evaluates and updates the point, and
// the step that enters region two switches first; a step with no active ellipse gives an empty result.
// One word is in flight at a time; the next is taken the cycle after the result enters the
// output register, and that register waits while the previous result is stalled.
// Reset (arst_n low) clears the controller, the output valid and the active ellipse.
module midpoint_ellipse_rasterizer import mer_pkg::*; #(
	parameter int RADIUS_BITS = 10,
	parameter int CENTER_BITS = 11
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      op,
	input  logic [RADIUS_BITS-1:0]    radius_x,
	input  logic [RADIUS_BITS-1:0]    radius_y,
	input  logic [CENTER_BITS-1:0]    center_x,
	input  logic [CENTER_BITS-1:0]    center_y,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [COORD_W-1:0] px_pp,
	output logic signed [COORD_W-1:0] py_pp,
	output logic signed [COORD_W-1:0] px_pm,
	output logic signed [COORD_W-1:0] py_pm,
	output logic signed [COORD_W-1:0] px_mp,
	output logic signed [COORD_W-1:0] py_mp,
	output logic signed [COORD_W-1:0] px_mm,
	output logic signed [COORD_W-1:0] py_mm,
	output logic                      last_point,
	output logic                      no_point
);

	dp_op_t  cmd;
	status_t status;

	mer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_op     (op),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	mer_dp #(
		.RADIUS_BITS (RADIUS_BITS),
		.CENTER_BITS (CENTER_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.radius_x   (radius_x),
		.radius_y   (radius_y),
		.center_x   (center_x),
		.center_y   (center_y),
		.px_pp      (px_pp),
		.py_pp      (py_pp),
		.px_pm      (px_pm),
		.py_pm      (py_pm),
		.px_mp      (px_mp),
		.py_mp      (py_mp),
		.px_mm      (px_mm),
		.py_mm      (py_mm),
		.last_point (last_point),
		.no_point   (no_point)
	);

endmodule

// ----- src/mer_checker.sv -----
// Port-level assertions for the midpoint ellipse rasterizer and their bind.
module mer_checker import mer_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic signed [COORD_W-1:0] px_pp,
	input logic                      last_point,
	input logic                      no_point
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Output word dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(px_pp) && $stable(last_point) && $stable(no_point))
		else $error("Output word changed while stalled.");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("Input word taken while another is in progress.");

	a_no_point_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_point |-> !last_point && (px_pp == '0))
		else $error("Empty step word carries point data.");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (.*);

// ----- test/midpoint_ellipse_rasterizer_tb.sv -----
// Self-checking testbench for the midpoint ellipse rasterizer with a point predictor and scoreboard.
module midpoint_ellipse_rasterizer_tb;
	import mer_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RADIUS_BITS = 10;
	localparam int CENTER_BITS = 11;
	localparam int TOTAL_WORDS = 1920;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic [7:0][COORD_W-1:0] coord;
		logic last;
		logic none;
	} point_t;

	class ellipse_scoreboard;
		point_t expected_q[$];
		int errors;
		int checked;
		string field_name [8] = '{"px_pp", "py_pp", "px_pm", "py_pm",
			"px_mp", "py_mp", "px_mm", "py_mm"};

		int unsigned x_pos, y_pos;
		bit [DEC_W-1:0] dec;
		bit region2;
		bit live;
		bit [RADIUS_BITS-1:0] hrx, hry;
		bit [CENTER_BITS-1:0] hcx, hcy;

		function int pending();
			return expected_q.size();
		endfunction

		function point_t emit_point(bit fin);
			point_t p;
			int sx, sy, ox, oy;
			sx = int'(hcx);
			sy = int'(hcy);
			ox = int'(x_pos);
			oy = int'(y_pos);
			p.coord[0] = COORD_W'(sx + ox);
			p.coord[1] = COORD_W'(sy + oy);
			p.coord[2] = COORD_W'(sx + ox);
			p.coord[3] = COORD_W'(sy - oy);
			p.coord[4] = COORD_W'(sx - ox);
			p.coord[5] = COORD_W'(sy + oy);
			p.coord[6] = COORD_W'(sx - ox);
			p.coord[7] = COORD_W'(sy - oy);
			p.last = fin;
			p.none = 1'b0;
			return p;
		endfunction

		function void note_word(logic opc, logic [RADIUS_BITS-1:0] rxi,
				logic [RADIUS_BITS-1:0] ryi, logic [CENTER_BITS-1:0] cxi,
				logic [CENTER_BITS-1:0] cyi);
			point_t p;
			bit [63:0] rx2, ry2, x, y, h, t;
			bit fin;
			if (opc == OP_START) begin
				hrx = rxi;
				hry = ryi;
				hcx = cxi;
				hcy = cyi;
				x_pos = 0;
				y_pos = int'(hry);
				rx2 = 64'(hrx) * 64'(hrx);
				ry2 = 64'(hry) * 64'(hry);
				dec = DEC_W'(4 * ry2 - 4 * rx2 * 64'(hry) + rx2);
				region2 = 1'b0;
				fin = (y_pos == 0);
				live = !fin;
				expected_q.push_back(emit_point(fin));
				return;
			end
			if (!live) begin
				p = '0;
				p.none = 1'b1;
				expected_q.push_back(p);
				return;
			end
			rx2 = 64'(hrx) * 64'(hrx);
			ry2 = 64'(hry) * 64'(hry);
			x = 64'(x_pos);
			y = 64'(y_pos);
			if (!region2 && ry2 * x < rx2 * y) begin
				x++;
				if (dec[DEC_W-1]) begin
					dec = DEC_W'(64'(dec) + 8 * ry2 * x + 4 * ry2);
				end else begin
					y--;
					dec = DEC_W'(64'(dec) + 8 * ry2 * x - 8 * rx2 * y + 4 * ry2);
				end
			end else begin
				if (!region2) begin
					h = 2 * x + 1;
					t = y - 1;
					dec = DEC_W'(ry2 * h * h + 4 * rx2 * t * t - 4 * rx2 * ry2);
					region2 = 1'b1;
				end
				y--;
				if (!dec[DEC_W-1] && dec != '0) begin
					dec = DEC_W'(64'(dec) + 4 * rx2 - 8 * rx2 * y);
				end else begin
					x++;
					dec = DEC_W'(64'(dec) + 8 * ry2 * x - 8 * rx2 * y + 4 * rx2);
				end
			end
			x_pos = 32'(x);
			y_pos = 32'(y);
			fin = (y_pos == 0);
			if (fin)
				live = 1'b0;
			expected_q.push_back(emit_point(fin));
		endfunction

		function void report(string what, logic signed [COORD_W-1:0] want,
				logic signed [COORD_W-1:0] got);
			errors++;
			if (errors <= 10)
				$display("point %0d: %s mismatch, expected %0d, got %0d",
					checked, what, want, got);
		endfunction

		function void check_point(point_t got);
			point_t want;
			checked++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("point %0d: result arrived with nothing pending", checked);
				return;
			end
			want = expected_q.pop_front();
			for (int i = 0; i < 8; i++)
				if (got.coord[i] !== want.coord[i])
					report(field_name[i], want.coord[i], got.coord[i]);
			if (got.last !== want.last)
				report("last_point", COORD_W'(want.last), COORD_W'(got.last));
			if (got.none !== want.none)
				report("no_point", COORD_W'(want.none), COORD_W'(got.none));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic op;
	logic [RADIUS_BITS-1:0] radius_x;
	logic [RADIUS_BITS-1:0] radius_y;
	logic [CENTER_BITS-1:0] center_x;
	logic [CENTER_BITS-1:0] center_y;
	logic out_valid;
	logic out_stall;
	logic signed [COORD_W-1:0] px_pp, py_pp, px_pm, py_pm;
	logic signed [COORD_W-1:0] px_mp, py_mp, px_mm, py_mm;
	logic last_point;
	logic no_point;

	ellipse_scoreboard sb = new();
	int words_sent;
	int results_seen;
	int idle_cycles;
	bit sender_quiet;

	midpoint_ellipse_rasterizer #(
		.RADIUS_BITS(RADIUS_BITS),
		.CENTER_BITS(CENTER_BITS)
	) u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_word(input logic o, input logic [RADIUS_BITS-1:0] rxi,
			input logic [RADIUS_BITS-1:0] ryi, input logic [CENTER_BITS-1:0] cxi,
			input logic [CENTER_BITS-1:0] cyi);
		int gap;
		in_valid <= 1'b1;
		op <= o;
		radius_x <= rxi;
		radius_y <= ryi;
		center_x <= cxi;
		center_y <= cyi;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_word(o, rxi, ryi, cxi, cyi);
		words_sent++;
		gap = sender_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic step_once();
		send_word(OP_STEP, RADIUS_BITS'($urandom), RADIUS_BITS'($urandom),
			CENTER_BITS'($urandom), CENTER_BITS'($urandom));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic random_sequence();
		int kind, size_kind, budget, n;
		logic [RADIUS_BITS-1:0] rx, ry;
		kind = $urandom_range(0, 99);
		sender_quiet = ($urandom_range(0, 3) == 0);
		if (kind < 8) begin
			n = $urandom_range(1, 4);
			repeat (n)
				send_word(1'($urandom_range(0, 1)), RADIUS_BITS'($urandom),
					RADIUS_BITS'($urandom), CENTER_BITS'($urandom), CENTER_BITS'($urandom));
			return;
		end
		size_kind = $urandom_range(0, 99);
		if (size_kind < 80) begin
			rx = RADIUS_BITS'($urandom_range(0, 31));
			ry = RADIUS_BITS'($urandom_range(0, 31));
			budget = 100000;
		end else if (size_kind < 95) begin
			rx = RADIUS_BITS'($urandom_range(0, 127));
			ry = RADIUS_BITS'($urandom_range(0, 127));
			budget = 100000;
		end else begin
			rx = RADIUS_BITS'($urandom);
			ry = RADIUS_BITS'($urandom);
			budget = $urandom_range(5, 60);
		end
		if ($urandom_range(0, 99) < 12)
			budget = $urandom_range(0, 8);
		send_word(OP_START, rx, ry, CENTER_BITS'($urandom), CENTER_BITS'($urandom));
		n = 0;
		while (sb.live && n < budget) begin
			step_once();
			n++;
		end
		if ($urandom_range(0, 99) < 25)
			repeat ($urandom_range(1, 2)) step_once();
		if ($urandom_range(0, 99) < 5)
			drain_results();
	endtask

	initial begin
		in_valid <= 1'b0;
		op <= OP_STEP;
		radius_x <= '0;
		radius_y <= '0;
		center_x <= '0;
		center_y <= '0;
		arst_n <= 1'b0;
		words_sent = 0;
		sender_quiet = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		step_once();
		send_word(OP_START, 10'd0, 10'd0, 11'd0, 11'd0);
		step_once();
		send_word(OP_START, 10'd1023, 10'd1023, 11'd2047, 11'd2047);
		repeat (3) step_once();
		send_word(OP_START, 10'd0, 10'd3, 11'd0, 11'd2047);
		repeat (4) step_once();
		send_word(OP_START, 10'd1023, 10'd0, 11'd1024, 11'd0);
		send_word(OP_START, 10'd3, 10'd2, 11'd0, 11'd0);
		repeat (8) step_once();
		drain_results();

		while (words_sent < TOTAL_WORDS)
			random_sequence();
		drain_results();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("midpoint_ellipse_rasterizer regression: pass");
		end else begin
			$display("midpoint_ellipse_rasterizer regression: fail");
		end
		$finish;
	end

	initial begin
		point_t got;
		int stall_left, hold_left, seg_left;
		bit recv_quiet;
		stall_left = 0;
		hold_left = 0;
		seg_left = 0;
		recv_quiet = 1'b0;
		results_seen = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.coord[0] = px_pp;
				got.coord[1] = py_pp;
				got.coord[2] = px_pm;
				got.coord[3] = py_pm;
				got.coord[4] = px_mp;
				got.coord[5] = py_mp;
				got.coord[6] = px_mm;
				got.coord[7] = py_mm;
				got.last = last_point;
				got.none = no_point;
				sb.check_point(got);
				results_seen++;
				if (results_seen == 400 || results_seen == 1300)
					hold_left = LONG_HOLD;
			end
			if (seg_left == 0) begin
				seg_left = $urandom_range(20, 200);
				recv_quiet = ($urandom_range(0, 3) == 0);
			end else begin
				seg_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!recv_quiet && $urandom_range(0, 99) < 25) begin
				stall_left = pick_gap();
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("midpoint_ellipse_rasterizer regression: fail");
		$finish;
	end

endmodule
